[design/rfrt_pkg.sv]
// Shared types and constants for the RTP frame reassembly tracker.
`default_nettype none

package rfrt_pkg;

  localparam int FRAME_BYTE_BITS   = 24;
  localparam int PACKET_COUNT_BITS = 16;
  localparam int SEQ_BITS          = 24;
  localparam int OUT_DEPTH         = 4;
  localparam int OUT_PTR_BITS      = $clog2(OUT_DEPTH);

  localparam logic [1:0] STATUS_EMITTED   = 2'd0;
  localparam logic [1:0] STATUS_TAIL_LOSS = 2'd1;
  localparam logic [1:0] STATUS_DAMAGED   = 2'd2;

  localparam logic CMD_MAIN = 1'b0;
  localparam logic CMD_BODY = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] pkt_timestamp;
    logic [15:0] pkt_sequence;
    logic [7:0]  seq_extension;
    logic        end_marker;
    logic [15:0] payload_length;
    logic [2:0]  tile_part_code;
    logic [2:0]  order_hint;
    logic [3:0]  header_flags;
    logic [23:0] colour_codes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic        final_result;
    logic [31:0] frame_timestamp;
    logic [23:0] frame_first_seq;
    logic [23:0] frame_last_seq;
    logic [15:0] frame_packets;
    logic [23:0] frame_bytes;
    logic        frame_has_meta;
    logic [2:0]  frame_tp;
    logic [2:0]  frame_ordh;
    logic [3:0]  frame_flags;
    logic [23:0] frame_colour;
  } out_item_t;

  // Up to two closed frames per packet word.
  typedef struct packed {
    logic      first_vld;
    logic      second_vld;
    out_item_t first;
    out_item_t second;
  } res_push_t;

endpackage

`default_nettype wire

[design/rtp_frame_reassembly_tracker.sv]
// RTP JPEG 2000 frame reassembly tracker: top level with the input register.
//
// Takes one received packet header word per cycle and reports each closed frame
// as a result word: a timestamp change closes the open frame before the packet
// is counted, a marker closes it after, so one packet yields zero, one or two
// results (final_result marks the last). A word is held in the input register,
// updates the frame state and lands in a four-entry result queue; the first
// result reaches the output through the input register and then the queue.
// Input throughput is one word per cycle while the queue has room for two
// results; output drains one result per cycle while out_ready_i is high, so a
// sustained run of two-result packets is held back by the queue.
`default_nettype none

module rtp_frame_reassembly_tracker import rfrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      stage_vld_q, stage_vld_d;
  in_item_t  stage_q;
  logic      room;
  logic      advance;
  res_push_t push;

  assign advance     = stage_vld_q && room;
  assign in_ready_o  = !stage_vld_q || advance;
  assign stage_vld_d = (in_valid_i && in_ready_o) || (stage_vld_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
    end
  end

  // Load a new word whenever the stage is free or drains this cycle.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_q <= in_data_i;
    end
  end

  rfrt_frame_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage_q),
    .push_o    (push)
  );

  rfrt_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[design/rfrt_frame_track.sv]
// Frame state registers and the per-packet update that closes frames.
`default_nettype none

module rfrt_frame_track import rfrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  in_item_t  item_i,
  output res_push_t push_o
);

  logic                         open_q, open_d;
  logic [31:0]                  ts_q, ts_d;
  logic [SEQ_BITS-1:0]          first_q, first_d;
  logic [SEQ_BITS-1:0]          last_q, last_d;
  logic [PACKET_COUNT_BITS-1:0] pcount_q, pcount_d;
  logic [FRAME_BYTE_BITS-1:0]   bytes_q, bytes_d;
  logic                         intact_q, intact_d;
  logic                         marker_q, marker_d;
  logic                         meta_q, meta_d;
  logic [2:0]                   tp_q, tp_d;
  logic [2:0]                   ordh_q, ordh_d;
  logic [3:0]                   flags_q, flags_d;
  logic [23:0]                  colour_q, colour_d;
  logic                         cached_q, cached_d;
  logic [15:0]                  clen_q, clen_d;
  logic                         nopkt_q, nopkt_d;
  logic [SEQ_BITS-1:0]          prev_q, prev_d;

  logic                         is_body;
  logic [SEQ_BITS-1:0]          ext;
  logic                         close_ts;
  logic                         still_open;
  logic                         gap;
  logic [PACKET_COUNT_BITS-1:0] pcount_base, pcount_new;
  logic [FRAME_BYTE_BITS-1:0]   bytes_base, bytes_new;
  logic [FRAME_BYTE_BITS:0]     bytes_sum;
  logic                         intact_base, intact_new;
  logic                         meta_base, meta_new;
  logic [31:0]                  ts_new;
  logic [SEQ_BITS-1:0]          first_new;
  logic [2:0]                   tp_new, ordh_new;
  logic [3:0]                   flags_new;
  logic [23:0]                  colour_new;
  out_item_t                    rec_old, rec_new;

  function automatic logic [1:0] status_f(input logic intact, input logic marker,
                                          input logic no_bytes);
    logic [1:0] s;
    if (!intact) s = STATUS_DAMAGED;
    else if (!marker) s = STATUS_TAIL_LOSS;
    else if (no_bytes) s = STATUS_DAMAGED;
    else s = STATUS_EMITTED;
    return s;
  endfunction

  assign is_body    = (item_i.command == CMD_BODY);
  assign ext        = {item_i.seq_extension, item_i.pkt_sequence};
  assign close_ts   = open_q && (item_i.pkt_timestamp != ts_q);
  assign still_open = open_q && !close_ts;
  assign gap        = !nopkt_q && (ext != SEQ_BITS'(prev_q + 1'b1));

  always_comb begin
    if (still_open) begin
      ts_new      = ts_q;
      first_new   = first_q;
      pcount_base = pcount_q;
      bytes_base  = bytes_q;
      intact_base = intact_q;
      meta_base   = meta_q;
    end else begin
      // Open a new frame; a body-first frame is credited with the cached header.
      ts_new      = item_i.pkt_timestamp;
      first_new   = ext;
      pcount_base = '0;
      meta_base   = 1'b0;
      if (is_body) begin
        bytes_base  = cached_q ? FRAME_BYTE_BITS'(clen_q) : '0;
        intact_base = cached_q;
      end else begin
        bytes_base  = '0;
        intact_base = 1'b1;
      end
    end
  end

  assign intact_new = intact_base && !gap;
  assign pcount_new = (&pcount_base) ? pcount_base : pcount_base + 1'b1;
  assign bytes_sum  = {1'b0, bytes_base} + (FRAME_BYTE_BITS + 1)'(item_i.payload_length);
  assign bytes_new  = bytes_sum[FRAME_BYTE_BITS] ? '1 : bytes_sum[FRAME_BYTE_BITS-1:0];
  assign meta_new   = meta_base || !is_body;
  assign tp_new     = is_body ? tp_q : item_i.tile_part_code;
  assign ordh_new   = is_body ? ordh_q : item_i.order_hint;
  assign flags_new  = is_body ? flags_q : item_i.header_flags;
  assign colour_new = is_body ? colour_q : item_i.colour_codes;

  always_comb begin
    rec_old.frame_status    = status_f(intact_q, marker_q, bytes_q == '0);
    rec_old.final_result    = !item_i.end_marker;
    rec_old.frame_timestamp = ts_q;
    rec_old.frame_first_seq = first_q;
    rec_old.frame_last_seq  = last_q;
    rec_old.frame_packets   = 16'(pcount_q);
    rec_old.frame_bytes     = 24'(bytes_q);
    rec_old.frame_has_meta  = meta_q;
    rec_old.frame_tp        = tp_q;
    rec_old.frame_ordh      = ordh_q;
    rec_old.frame_flags     = flags_q;
    rec_old.frame_colour    = colour_q;

    rec_new.frame_status    = status_f(intact_new, 1'b1, bytes_new == '0);
    rec_new.final_result    = 1'b1;
    rec_new.frame_timestamp = ts_new;
    rec_new.frame_first_seq = first_new;
    rec_new.frame_last_seq  = ext;
    rec_new.frame_packets   = 16'(pcount_new);
    rec_new.frame_bytes     = 24'(bytes_new);
    rec_new.frame_has_meta  = meta_new;
    rec_new.frame_tp        = tp_new;
    rec_new.frame_ordh      = ordh_new;
    rec_new.frame_flags     = flags_new;
    rec_new.frame_colour    = colour_new;
  end

  always_comb begin
    push_o.first_vld  = advance_i && (close_ts || item_i.end_marker);
    push_o.second_vld = advance_i && close_ts && item_i.end_marker;
    push_o.first      = close_ts ? rec_old : rec_new;
    push_o.second     = rec_new;
  end

  always_comb begin
    ts_d     = ts_new;
    first_d  = first_new;
    last_d   = ext;
    bytes_d  = bytes_new;
    marker_d = item_i.end_marker;
    tp_d     = tp_new;
    ordh_d   = ordh_new;
    flags_d  = flags_new;
    colour_d = colour_new;
    nopkt_d  = 1'b0;
    prev_d   = ext;
    cached_d = cached_q;
    clen_d   = clen_q;
    if (!is_body && item_i.header_flags[0] && (item_i.payload_length != '0)) begin
      cached_d = 1'b1;
      clen_d   = item_i.payload_length;
    end
    if (item_i.end_marker) begin
      // Marker closes the frame after the packet is taken.
      open_d   = 1'b0;
      pcount_d = '0;
      intact_d = 1'b1;
      meta_d   = 1'b0;
    end else begin
      open_d   = 1'b1;
      pcount_d = pcount_new;
      intact_d = intact_new;
      meta_d   = meta_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      ts_q     <= '0;
      first_q  <= '0;
      last_q   <= '0;
      pcount_q <= '0;
      bytes_q  <= '0;
      intact_q <= 1'b1;
      marker_q <= 1'b0;
      meta_q   <= 1'b0;
      tp_q     <= '0;
      ordh_q   <= '0;
      flags_q  <= '0;
      colour_q <= '0;
      cached_q <= 1'b0;
      clen_q   <= '0;
      nopkt_q  <= 1'b1;
      prev_q   <= '0;
    end else if (advance_i) begin
      open_q   <= open_d;
      ts_q     <= ts_d;
      first_q  <= first_d;
      last_q   <= last_d;
      pcount_q <= pcount_d;
      bytes_q  <= bytes_d;
      intact_q <= intact_d;
      marker_q <= marker_d;
      meta_q   <= meta_d;
      tp_q     <= tp_d;
      ordh_q   <= ordh_d;
      flags_q  <= flags_d;
      colour_q <= colour_d;
      cached_q <= cached_d;
      clen_q   <= clen_d;
      nopkt_q  <= nopkt_d;
      prev_q   <= prev_d;
    end
  end

endmodule

`default_nettype wire

[design/rfrt_out_queue.sv]
// Result queue: takes up to two results a cycle, hands out one a cycle while out_ready_i is high.
`default_nettype none

module rfrt_out_queue import rfrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  out_item_t               mem_q [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] wr_q, wr_d;
  logic [OUT_PTR_BITS-1:0] rd_q, rd_d;
  logic [OUT_PTR_BITS:0]   cnt_q, cnt_d;
  logic                    pop;
  logic [OUT_PTR_BITS:0]   n_push;
  logic [OUT_PTR_BITS-1:0] wr_next;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // Leave space for a full pair of results.
  assign room_o      = (cnt_q <= (OUT_PTR_BITS + 1)'(OUT_DEPTH - 2));
  assign n_push      = (OUT_PTR_BITS + 1)'(push_i.first_vld)
                     + (OUT_PTR_BITS + 1)'(push_i.second_vld);
  assign wr_next     = wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q + OUT_PTR_BITS'(n_push);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + n_push - (OUT_PTR_BITS + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first_vld) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.second_vld) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire
